// ===== hdl/smrd_pkg.sv =====
// package: types, constants and helpers for the static model range decoder
package smrd_pkg;

    localparam int PROB_BITS  = 14;
    localparam int FIFO_DEPTH = 8;
    localparam int SYMBOLS    = 256;

    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int IDX_W  = $clog2(SYMBOLS + 1);
    localparam int CUM_W  = PROB_BITS + 1;
    localparam int FPTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FREQ_W = 15;

    localparam logic [CUM_W-1:0] PROB_ONE = CUM_W'(1) << PROB_BITS;
    localparam logic [2:0] PAD_LIMIT = 3'd5;

    typedef enum logic [1:0] {
        K_LOAD    = 2'd0,
        K_PUSH    = 2'd1,
        K_END     = 2'd2,
        K_REQUEST = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEED    = 2'd1,
        ST_EXHAUST = 2'd2,
        ST_CORRUPT = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PRIME,
        S_SRCH_RD,
        S_SRCH_MUL,
        S_SRCH_CMP,
        S_SEL_RD,
        S_SEL_LO,
        S_SEL_HI,
        S_NAR_MUL,
        S_NAR_ADD,
        S_NAR_CHK,
        S_OCT,
        S_SQZ,
        S_FIN,
        S_COMMIT,
        S_OUT
    } t_state;

endpackage

// ===== hdl/static_model_range_decoder.sv =====
// top level: static model arithmetic range decoder
//
// one input channel (i_valid/o_stall) carries requests of four kinds:
// load frequency, push compressed byte, end of stream and request symbol.
// one output channel (o_valid/i_stall) carries a result for each symbol
// request: symbol, status and last. loads, pushes and end marks give no
// result and are taken one per cycle while the decoder is idle and no result waits.
// a symbol request walks the cumulative table held in a one-port
// synchronous memory by binary search, one table read and a 15x35 and a
// 15x14 partial product per step, eight steps in all; then it reads both
// bounds, narrows and renormalizes one octet per cycle. the first request
// first primes the code value from six bytes. short-stream and
// need-more-bytes results come out before the full walk is done.
// one request is worked on at a time; the input is stalled meanwhile.
// a finished result sits in the output register until taken; while the
// receiver stalls, no new request is taken.
// reset is synchronous and active low: it empties the byte fifo, clears the
// load position, the sum and the decoder state; the table is not cleared.
module static_model_range_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [14:0] i_freq,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_symbol,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam int SW = smrd_pkg::SYM_W;
    localparam int IW = smrd_pkg::IDX_W;
    localparam int CW = smrd_pkg::CUM_W;
    localparam int PB = smrd_pkg::PROB_BITS;
    localparam int FD = smrd_pkg::FIFO_DEPTH;
    localparam int FPW = smrd_pkg::FPTR_W;
    localparam int FCW = smrd_pkg::FCNT_W;

    // cumulative table memory
    logic [CW-1:0] r_mem [0:smrd_pkg::SYMBOLS-1];
    logic [CW-1:0] r_rdata;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [CW-1:0] rd_val;
    logic          r_rd_top;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata  <= r_mem[mem_raddr[SW-1:0]];
        r_rd_top <= (mem_raddr == IW'(smrd_pkg::SYMBOLS));
    end

    assign rd_val = r_rd_top ? smrd_pkg::PROB_ONE : r_rdata;

    // byte fifo (registers at fixed taps, shifted on consume)
    logic [7:0]     r_fifo [0:FD-1];
    logic [FCW-1:0] r_fcnt;
    logic           r_end;
    logic [2:0]     r_pad;
    logic [31:0]    r_symcnt, r_dec;
    logic           r_primed;
    logic [IW-1:0]  r_lidx;
    logic [CW-1:0]  r_rsum;
    logic [47:0]    r_lo, r_val;
    logic [48:0]    r_rng;

    // working registers
    smrd_pkg::t_state r_st, n_st;
    logic [47:0] r_wval, n_wval, r_wlo, n_wlo;
    logic [48:0] r_wrng, n_wrng;
    logic [FCW-1:0] r_tpos, n_tpos;
    logic [3:0]  r_tpad, n_tpad;
    logic [2:0]  r_k, n_k;
    logic [SW:0] r_blo, n_blo, r_bhi, n_bhi;
    logic [SW:0] r_c, n_c;
    logic [CW-1:0] r_cl, n_cl, r_ch, n_ch;
    logic [48:0] r_mh, n_mh, r_ml, n_ml;
    logic [47:0] r_delta, n_delta;
    logic [47:0] r_dbits, n_dbits;
    logic [7:0]  r_osym, n_osym;
    logic [1:0]  r_ostat, n_ostat;
    logic        r_olast, n_olast, r_ovalid, n_ovalid;
    logic        do_commit, do_consume;

    logic        fifo_ok;
    logic [7:0]  fbyte;
    logic [SW:0] mid;
    logic [CW-1:0] mul_f;
    logic [48:0] scale_sum;
    logic [48:0] hi_w;
    logic        acc;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_st != smrd_pkg::S_IDLE) || r_ovalid;
    assign fifo_ok = (r_tpos < r_fcnt) || r_end;
    assign fbyte   = (r_tpos < r_fcnt) ? r_fifo[r_tpos[FPW-1:0]] : 8'd0;
    assign mid     = (r_blo + r_bhi + (SW+1)'(1)) >> 1;

    // ceil or floor of (f*r)>>PB from the two registered partial products
    assign scale_sum = r_mh + (r_ml >> PB);
    assign hi_w      = 49'(r_wlo) + r_wrng - 49'd1;

    always_comb begin
        n_st = r_st; n_wval = r_wval; n_wlo = r_wlo; n_wrng = r_wrng;
        n_tpos = r_tpos; n_tpad = r_tpad; n_k = r_k;
        n_blo = r_blo; n_bhi = r_bhi; n_c = r_c; n_cl = r_cl; n_ch = r_ch;
        n_mh = r_mh; n_ml = r_ml; n_delta = r_delta; n_dbits = r_dbits;
        n_osym = r_osym; n_ostat = r_ostat; n_olast = r_olast;
        n_ovalid = r_ovalid && i_stall;
        mem_we = 1'b0; mem_waddr = r_lidx[SW-1:0]; mem_wdata = r_rsum;
        mem_raddr = mid; mul_f = rd_val;
        do_commit = 1'b0; do_consume = 1'b0;
        case (r_st)
            smrd_pkg::S_IDLE: begin
                if (acc && i_kind == smrd_pkg::K_LOAD &&
                        r_lidx < IW'(smrd_pkg::SYMBOLS)) begin
                    mem_we = 1'b1;
                end
                if (acc && i_kind == smrd_pkg::K_REQUEST) begin
                    n_wval = r_val; n_wlo = r_lo; n_wrng = r_rng;
                    n_tpos = '0; n_tpad = '0; n_k = '0;
                    n_olast = 1'b0;
                    if (!r_primed) begin
                        n_wval = '0;
                        if (r_end && r_fcnt < FCW'(2)) begin
                            n_osym = '0; n_ostat = smrd_pkg::ST_EXHAUST;
                            n_st = smrd_pkg::S_OUT;
                        end else begin
                            n_st = smrd_pkg::S_PRIME;
                        end
                    end else begin
                        n_st = smrd_pkg::S_SRCH_RD;
                    end
                    n_blo = '0; n_bhi = (SW+1)'(smrd_pkg::SYMBOLS - 1);
                end
            end
            smrd_pkg::S_PRIME: begin
                if (!fifo_ok) begin
                    n_osym = '0; n_ostat = smrd_pkg::ST_NEED; n_st = smrd_pkg::S_OUT;
                end else begin
                    n_wval = {r_wval[39:0], fbyte};
                    if (r_tpos < r_fcnt) n_tpos = r_tpos + FCW'(1);
                    else n_tpad = r_tpad + 4'd1;
                    n_k = r_k + 3'd1;
                    if (r_k == 3'd5) n_st = smrd_pkg::S_SRCH_RD;
                end
            end
            smrd_pkg::S_SRCH_RD: begin
                n_delta = r_wval - r_wlo;
                if (r_blo == r_bhi) begin
                    n_c = r_blo; n_st = smrd_pkg::S_SEL_RD;
                end else begin
                    mem_raddr = mid; n_st = smrd_pkg::S_SRCH_MUL;
                end
            end
            smrd_pkg::S_SRCH_MUL: begin
                n_mh = 49'(64'(rd_val) * 64'(r_wrng >> PB));
                n_ml = 49'(rd_val) * 49'(r_wrng[PB-1:0]) + 49'((1 << PB) - 1);
                n_st = smrd_pkg::S_SRCH_CMP;
            end
            smrd_pkg::S_SRCH_CMP: begin
                if (scale_sum <= 49'(r_delta)) n_blo = mid;
                else n_bhi = mid - (SW+1)'(1);
                n_st = smrd_pkg::S_SRCH_RD;
            end
            smrd_pkg::S_SEL_RD: begin
                n_osym = r_c[SW-1:0];
                if ((r_dec + 32'd1) == r_symcnt) begin
                    n_ostat = smrd_pkg::ST_OK; n_olast = 1'b1;
                    do_consume = 1'b1; n_st = smrd_pkg::S_OUT;
                end else begin
                    mem_raddr = r_c; n_st = smrd_pkg::S_SEL_LO;
                end
            end
            smrd_pkg::S_SEL_LO: begin
                n_cl = rd_val; mem_raddr = r_c + (SW+1)'(1);
                n_st = smrd_pkg::S_SEL_HI;
            end
            smrd_pkg::S_SEL_HI: begin
                n_ch = rd_val;
                n_mh = 49'(64'(r_cl) * 64'(r_wrng >> PB));
                n_ml = 49'(r_cl) * 49'(r_wrng[PB-1:0]) + 49'((1 << PB) - 1);
                n_st = smrd_pkg::S_NAR_MUL;
            end
            smrd_pkg::S_NAR_MUL: begin
                n_wlo = r_wlo + scale_sum[47:0];
                mul_f = (r_ch > r_cl) ? r_ch - r_cl : '0;
                n_mh = 49'(64'(mul_f) * 64'(r_wrng >> PB));
                n_ml = 49'(mul_f) * 49'(r_wrng[PB-1:0]);
                n_st = smrd_pkg::S_NAR_ADD;
            end
            smrd_pkg::S_NAR_ADD: begin
                n_wrng = scale_sum;
                n_st = smrd_pkg::S_NAR_CHK;
            end
            smrd_pkg::S_NAR_CHK: begin
                if (49'(r_wval - r_wlo) >= r_wrng || r_wrng == 49'd1) begin
                    n_ostat = smrd_pkg::ST_CORRUPT; n_st = smrd_pkg::S_OUT;
                end else if (r_wrng <= 49'h8000_0000) begin
                    n_dbits = r_wlo ^ hi_w[47:0]; n_k = '0;
                    n_st = smrd_pkg::S_OCT;
                end else begin
                    n_st = smrd_pkg::S_COMMIT;
                end
            end
            smrd_pkg::S_OCT: begin
                if (r_dbits[47:40] == 8'd0 && r_k < 3'd6) begin
                    if (!fifo_ok) begin
                        n_osym = '0; n_ostat = smrd_pkg::ST_NEED;
                        n_st = smrd_pkg::S_OUT;
                    end else begin
                        n_wval = {r_wval[39:0], fbyte};
                        if (r_tpos < r_fcnt) n_tpos = r_tpos + FCW'(1);
                        else n_tpad = r_tpad + 4'd1;
                        n_dbits = r_dbits << 8;
                        n_wrng = r_wrng << 8;
                        n_wlo = r_wlo << 8;
                        n_k = r_k + 3'd1;
                    end
                end else begin
                    n_st = smrd_pkg::S_SQZ;
                end
            end
            smrd_pkg::S_SQZ: begin
                if (r_wrng <= 49'h8000_0000) begin
                    if (!fifo_ok) begin
                        n_osym = '0; n_ostat = smrd_pkg::ST_NEED;
                        n_st = smrd_pkg::S_OUT;
                    end else begin
                        n_wlo = {r_wlo[47:40], r_wlo[31:0], 8'd0};
                        n_wval = {r_wval[47:40], r_wval[31:0], fbyte};
                        n_wrng = r_wrng << 8;
                        if (r_tpos < r_fcnt) n_tpos = r_tpos + FCW'(1);
                        else n_tpad = r_tpad + 4'd1;
                    end
                end else begin
                    n_st = smrd_pkg::S_FIN;
                end
            end
            smrd_pkg::S_FIN: begin
                if (5'(r_pad) + 5'(r_tpad) > 5'(smrd_pkg::PAD_LIMIT)) begin
                    n_ostat = smrd_pkg::ST_EXHAUST; n_st = smrd_pkg::S_OUT;
                end else if (49'(r_wval) - 49'(r_wlo) >= r_wrng) begin
                    n_ostat = smrd_pkg::ST_CORRUPT; n_st = smrd_pkg::S_OUT;
                end else begin
                    n_st = smrd_pkg::S_COMMIT;
                end
            end
            smrd_pkg::S_COMMIT: begin
                do_commit = 1'b1; do_consume = 1'b1;
                n_ostat = smrd_pkg::ST_OK; n_st = smrd_pkg::S_OUT;
            end
            smrd_pkg::S_OUT: begin
                n_ovalid = 1'b1; n_st = smrd_pkg::S_IDLE;
            end
            default: n_st = smrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= smrd_pkg::S_IDLE; r_ovalid <= 1'b0;
            r_fcnt <= '0; r_end <= 1'b0; r_pad <= '0; r_symcnt <= '0;
            r_dec <= '0; r_primed <= 1'b0; r_lidx <= '0; r_rsum <= '0;
            r_lo <= '0; r_val <= '0; r_rng <= 49'd1 << 48;
        end else begin
            r_st <= n_st; r_ovalid <= n_ovalid;
            if (i_cfg_we) r_symcnt <= i_cfg_data;
            if (acc && i_kind == smrd_pkg::K_LOAD &&
                    r_lidx < IW'(smrd_pkg::SYMBOLS)) begin
                r_lidx <= r_lidx + IW'(1);
                if (16'(r_rsum) + 16'(i_freq) > 16'(smrd_pkg::PROB_ONE))
                    r_rsum <= smrd_pkg::PROB_ONE;
                else r_rsum <= CW'(r_rsum + i_freq);
            end
            if (acc && i_kind == smrd_pkg::K_PUSH && !r_end &&
                    r_fcnt < FCW'(FD)) begin
                r_fcnt <= r_fcnt + FCW'(1);
            end
            if (acc && i_kind == smrd_pkg::K_END) r_end <= 1'b1;
            if (do_consume) begin
                r_val <= r_wval; r_primed <= 1'b1;
                r_fcnt <= r_fcnt - r_tpos;
                r_pad <= r_pad + r_tpad[2:0];
            end
            if (do_commit) begin
                r_lo <= r_wlo; r_rng <= r_wrng;
                r_dec <= r_dec + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_kind == smrd_pkg::K_PUSH && !r_end && r_fcnt < FCW'(FD)) begin
            r_fifo[r_fcnt[FPW-1:0]] <= i_data_byte;
        end
        if (do_consume) begin
            for (int j = 0; j < FD; j++) begin
                if (j + int'(r_tpos) < FD) r_fifo[j] <= r_fifo[j + int'(r_tpos)];
            end
        end
        r_wval <= n_wval; r_wlo <= n_wlo; r_wrng <= n_wrng;
        r_tpos <= n_tpos; r_tpad <= n_tpad; r_k <= n_k;
        r_blo <= n_blo; r_bhi <= n_bhi; r_c <= n_c; r_cl <= n_cl; r_ch <= n_ch;
        r_mh <= n_mh; r_ml <= n_ml; r_delta <= n_delta; r_dbits <= n_dbits;
        r_osym <= n_osym; r_ostat <= n_ostat; r_olast <= n_olast;
    end

    assign o_valid  = r_ovalid;
    assign o_symbol = r_osym;
    assign o_status = r_ostat;
    assign o_last   = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != smrd_pkg::S_IDLE) |-> !acc) else $error("request taken while busy");
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FCW'(FD)) else $error("fifo count overflow");
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_status == smrd_pkg::ST_OK)) else $error("last without ok");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_symbol) && $stable(o_status)))
        else $error("result dropped under stall");
`endif

endmodule

// ===== sim/smrd_checker.sv =====
// checker: watches the decoder channels, predicts each symbol result and compares
module smrd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [14:0] i_freq,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_symbol,
    input  logic [1:0]  i_status,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] ONE14  = 64'd1 << smrd_pkg::PROB_BITS;
    localparam bit [63:0] M48    = (64'd1 << 48) - 64'd1;
    localparam bit [63:0] M31_0  = (64'd1 << 32) - 64'd1;
    localparam bit [63:0] M47_40 = (64'd1 << 48) - (64'd1 << 40);
    localparam bit [63:0] SQZ_AT = 64'd1 << 31;

    typedef struct packed {
        logic [7:0] sym;
        logic [1:0] st;
        logic       lst;
    } t_symbol_res;

    t_symbol_res symbol_q[$];

    bit [14:0]  cum_tab [0:smrd_pkg::SYMBOLS];
    int unsigned load_pos, cum_sum, fifo_cnt, pad_cnt;
    bit [31:0]  sym_total, done_cnt;
    bit [63:0]  low_r, range_r, code_r;
    bit [7:0]   fifo [0:smrd_pkg::FIFO_DEPTH-1];
    bit         end_mark, primed;

    function automatic bit [63:0] scale_frac(bit [63:0] r, bit [63:0] f, bit up);
        bit [63:0] part;
        part = f * (r & (ONE14 - 1)) + (up ? ONE14 - 1 : 64'd0);
        return f * (r >> smrd_pkg::PROB_BITS) + (part >> smrd_pkg::PROB_BITS);
    endfunction

    function automatic bit next_byte(inout int unsigned pos, inout int unsigned pad,
                                     output bit [63:0] b);
        b = 0;
        if (pos < fifo_cnt) begin
            b = 64'(fifo[pos]);
            pos++;
            return 1;
        end
        if (end_mark) begin
            pad++;
            return 1;
        end
        return 0;
    endfunction

    function automatic void drop_bytes(int unsigned pos, int unsigned pad);
        for (int i = 0; i + pos < fifo_cnt; i++) fifo[i] = fifo[i + pos];
        fifo_cnt -= pos;
        pad_cnt  += pad;
    endfunction

    function automatic t_symbol_res decode_symbol();
        t_symbol_res r;
        bit [63:0] val, lo, rng, b, delta, hi, dbits, cl, ch;
        int unsigned pos, pad, k, c;
        r = '{sym: 8'd0, st: smrd_pkg::ST_OK, lst: 1'b0};
        val = code_r; lo = low_r; rng = range_r;
        pos = 0; pad = 0; c = 0;
        if (!primed) begin
            if (end_mark && fifo_cnt < 2) begin
                r.st = smrd_pkg::ST_EXHAUST;
                return r;
            end
            val = 0;
            for (k = 0; k < 6; k++) begin
                if (!next_byte(pos, pad, b)) begin
                    r.st = smrd_pkg::ST_NEED;
                    return r;
                end
                val = (val << 8) | b;
            end
        end
        delta = val - lo;
        for (int s = 0; s < smrd_pkg::SYMBOLS; s++)
            if (scale_frac(rng, 64'(cum_tab[s]), 1'b1) <= delta) c = s;
        r.sym = 8'(c);
        if (done_cnt + 32'd1 == sym_total) begin
            code_r = val;
            primed = 1;
            drop_bytes(pos, pad);
            r.lst = 1;
            return r;
        end
        cl = 64'(cum_tab[c]);
        ch = 64'(cum_tab[c+1]);
        lo += scale_frac(rng, cl, 1'b1);
        rng = scale_frac(rng, ch > cl ? ch - cl : 64'd0, 1'b0);
        if (val - lo >= rng || rng == 1) begin
            r.st = smrd_pkg::ST_CORRUPT;
            return r;
        end
        if (rng <= SQZ_AT) begin
            hi = lo + rng - 1;
            dbits = lo ^ hi;
            k = 0;
            while ((dbits >> 40) == 0 && k < 6) begin
                if (!next_byte(pos, pad, b)) begin
                    r.sym = 0;
                    r.st = smrd_pkg::ST_NEED;
                    return r;
                end
                val = (val << 8) | b;
                dbits <<= 8;
                k++;
            end
            val &= M48;
            rng <<= 8 * k;
            lo = (lo << (8 * k)) & M48;
            while (rng <= SQZ_AT) begin
                if (!next_byte(pos, pad, b)) begin
                    r.sym = 0;
                    r.st = smrd_pkg::ST_NEED;
                    return r;
                end
                lo  = (lo & M47_40) | ((lo & M31_0) << 8);
                val = (val & M47_40) | ((val & M31_0) << 8) | b;
                rng <<= 8;
            end
            if (pad_cnt + pad > 32'(smrd_pkg::PAD_LIMIT)) begin
                r.st = smrd_pkg::ST_EXHAUST;
                return r;
            end
            if (val - lo >= rng) begin
                r.st = smrd_pkg::ST_CORRUPT;
                return r;
            end
        end
        low_r = lo;
        range_r = rng;
        code_r = val;
        primed = 1;
        drop_bytes(pos, pad);
        done_cnt++;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_symbol_res got, want;
        int unsigned sum;
        if (!i_rst_n) begin
            symbol_q.delete();
            cum_tab[smrd_pkg::SYMBOLS] = smrd_pkg::PROB_ONE;
            load_pos = 0; cum_sum = 0; sym_total = 0; done_cnt = 0;
            low_r = 0; range_r = 64'd1 << 48; code_r = 0;
            fifo_cnt = 0; end_mark = 0; pad_cnt = 0; primed = 0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) sym_total = i_cfg_data;
            if (i_valid && !i_in_stall) begin
                case (smrd_pkg::t_kind'(i_kind))
                    smrd_pkg::K_LOAD: begin
                        if (load_pos < smrd_pkg::SYMBOLS) begin
                            cum_tab[load_pos] = 15'(cum_sum);
                            sum = cum_sum + 32'(i_freq);
                            cum_sum = (sum > 32'(ONE14)) ? 32'(ONE14) : sum;
                            load_pos++;
                        end
                    end
                    smrd_pkg::K_PUSH: begin
                        if (!end_mark && fifo_cnt < smrd_pkg::FIFO_DEPTH) begin
                            fifo[fifo_cnt] = i_data_byte;
                            fifo_cnt++;
                        end
                    end
                    smrd_pkg::K_END: end_mark = 1;
                    default: symbol_q.push_back(decode_symbol());
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{sym: i_symbol, st: i_status, lst: i_last};
                if (symbol_q.size() == 0) begin
                    $display("%0t: result with none expected: sym %0d st %0d last %0d",
                             $time, got.sym, got.st, got.lst);
                    o_errors++;
                end else begin
                    want = symbol_q.pop_front();
                    if (got != want) begin
                        $display({"%0t: mismatch exp sym %0d st %0d last %0d, ",
                                  "got sym %0d st %0d last %0d"},
                                 $time, want.sym, want.st, want.lst,
                                 got.sym, got.st, got.lst);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = symbol_q.size();
    end

endmodule

// ===== sim/tb_static_model_range_decoder.sv =====
// testbench top: drives the range decoder and reports the verdict
module tb_static_model_range_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [31:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_kind = smrd_pkg::K_LOAD;
    logic [14:0] i_freq = 0;
    logic [7:0]  i_data_byte = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [7:0]  o_symbol;
    logic [1:0]  o_status;
    logic        o_last;
    int          errors, pending;
    int          cyc = 0;
    int          rx_cnt = 0;

    always #2 i_clk = ~i_clk;

    static_model_range_decoder dut (.*);

    smrd_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid,
        .i_in_stall(o_stall), .i_kind, .i_freq, .i_data_byte,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_symbol(o_symbol),
        .i_status(o_status), .i_last(o_last), .o_errors(errors), .o_pending(pending)
    );

    wire quiet = cyc >= 9000 && cyc < 15000;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall, one long hold-off
    always @(negedge i_clk) begin
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt >= 3000 && rx_cnt < 3600)
            i_stall <= 1;
        else
            i_stall <= !quiet && $urandom_range(99) < 22;
    end

    task automatic send_request(smrd_pkg::t_kind k, logic [14:0] f, logic [7:0] d);
        while (!quiet && $urandom_range(99) < 22) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_kind <= k;
        i_freq <= f;
        i_data_byte <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_count(logic [31:0] v);
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    task automatic random_mix(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 46)
                send_request(smrd_pkg::K_PUSH, 15'($urandom), 8'($urandom));
            else if (r < 92)
                send_request(smrd_pkg::K_REQUEST, 15'($urandom), 8'($urandom));
            else
                send_request(smrd_pkg::K_LOAD, 15'($urandom_range(32767)), 8'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        write_count(32'd1);
        send_request(smrd_pkg::K_REQUEST, 15'd0, 8'd0);
        for (int s = 0; s < smrd_pkg::SYMBOLS; s++)
            send_request(smrd_pkg::K_LOAD,
                         (s % 37 == 5) ? 15'd0 : 15'($urandom_range(1, 120)), 8'd0);
        send_request(smrd_pkg::K_LOAD, 15'd32767, 8'd0);
        send_request(smrd_pkg::K_LOAD, 15'd16384, 8'd0);
        send_request(smrd_pkg::K_REQUEST, 15'd0, 8'd0);
        send_request(smrd_pkg::K_PUSH, 15'd0, 8'hFF);
        send_request(smrd_pkg::K_PUSH, 15'd0, 8'h00);
        for (int i = 0; i < 4; i++) send_request(smrd_pkg::K_PUSH, 15'd0, 8'($urandom));
        send_request(smrd_pkg::K_REQUEST, 15'd0, 8'd0);
        send_request(smrd_pkg::K_REQUEST, 15'd0, 8'd0);
        write_count(32'd0);
        random_mix(500);
        write_count(32'hFFFF_FFFF);
        random_mix(500);
        write_count($urandom_range(32'h7FFF_FFFF, 32'hFFFF_FFFE));
        random_mix(200);
        send_request(smrd_pkg::K_END, 15'd0, 8'd0);
        for (int i = 0; i < 30; i++) begin
            send_request(smrd_pkg::K_PUSH, 15'd0, 8'($urandom));
            send_request(smrd_pkg::K_REQUEST, 15'd0, 8'd0);
        end
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
